FILE: design/vivf_pkg.sv
package vivf_pkg;

  localparam int CordicSteps = 16;
  localparam int DivSteps    = 32;

  localparam logic signed [33:0] GainQ30    = 34'sd652032874;
  localparam logic signed [15:0] EighthTurn = 16'sd8192;
  localparam logic [15:0]        HalfTurn   = 16'h8000;
  localparam logic [51:0]        VarScale   = 52'd1000000;
  localparam logic [51:0]        ZeroVarE   = 52'd65536;

  typedef enum logic [1:0] {
    POL_SKIP,
    POL_OVERWRITE,
    POL_FUSION,
    POL_UNKNOWN
  } policy_t;

  // arctan(2^-i) in binary angle units
  function automatic logic [15:0] ang_step(input int idx);
    logic [15:0] a;
    case (idx)
      0:       a = 16'd8192;
      1:       a = 16'd4836;
      2:       a = 16'd2555;
      3:       a = 16'd1297;
      4:       a = 16'd651;
      5:       a = 16'd326;
      6:       a = 16'd163;
      7:       a = 16'd81;
      8:       a = 16'd41;
      9:       a = 16'd20;
      10:      a = 16'd10;
      11:      a = 16'd5;
      12:      a = 16'd3;
      13:      a = 16'd1;
      14:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Everything one request carries down the pipe; each stage fills its part.
  typedef struct packed {
    policy_t                pol;
    logic signed [15:0]     mh;
    logic signed [15:0]     sh;
    logic signed [31:0]     mvx;
    logic signed [31:0]     mvy;
    logic signed [31:0]     svx;
    logic signed [31:0]     svy;
    logic [31:0]            mvar;
    logic [31:0]            svarx;
    logic [31:0]            svary;
    logic                   mzero;
    logic                   szero;
    logic                   neg;
    logic signed [35:0]     mx;
    logic signed [35:0]     my;
    logic [15:0]            mz;
    logic signed [35:0]     sx;
    logic signed [35:0]     sy;
    logic [15:0]            sz;
    logic signed [33:0]     rx;
    logic signed [33:0]     ry;
    logic signed [17:0]     rz;
    logic                   same;
    logic signed [65:0]     pc;
    logic signed [65:0]     ps;
    logic [67:0]            cc;
    logic [67:0]            ss;
    logic signed [36:0]     r;
    logic [31:0]            c2;
    logic [31:0]            s2;
    logic [63:0]            vxp;
    logic [63:0]            vyp;
    logic [31:0]            vs;
    logic [51:0]            em;
    logic [51:0]            es;
    logic [63:0]            prod;
    logic [32:0]            vsum;
    logic [35:0]            fr_rem;
    logic [31:0]            fr_low;
    logic [34:0]            fr_den;
    logic [35:0]            vr_rem;
    logic [31:0]            vr_low;
    logic [32:0]            vr_den;
    logic signed [67:0]     dp;
  } pipe_t;

endpackage

FILE: design/vivf_cordic_cell.sv
module vivf_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  vivf_pkg::pipe_t d_i,
  output logic            vld_o,
  output vivf_pkg::pipe_t d_o
);

  localparam logic [15:0] Ang = vivf_pkg::ang_step(STEP);

  vivf_pkg::pipe_t    nxt;
  logic signed [35:0] mdx, mdy, sdx, sdy;
  logic signed [33:0] rdx, rdy;
  logic               vld_r;
  vivf_pkg::pipe_t    d_r;

  always_comb begin
    nxt = d_i;
    mdx = d_i.my >>> STEP;
    mdy = d_i.mx >>> STEP;
    sdx = d_i.sy >>> STEP;
    sdy = d_i.sx >>> STEP;
    rdx = d_i.ry >>> STEP;
    rdy = d_i.rx >>> STEP;
    // vectoring: drive y toward zero
    if (d_i.my > 0) begin
      nxt.mx = d_i.mx + mdx;
      nxt.my = d_i.my - mdy;
      nxt.mz = d_i.mz + Ang;
    end else begin
      nxt.mx = d_i.mx - mdx;
      nxt.my = d_i.my + mdy;
      nxt.mz = d_i.mz - Ang;
    end
    if (d_i.sy > 0) begin
      nxt.sx = d_i.sx + sdx;
      nxt.sy = d_i.sy - sdy;
      nxt.sz = d_i.sz + Ang;
    end else begin
      nxt.sx = d_i.sx - sdx;
      nxt.sy = d_i.sy + sdy;
      nxt.sz = d_i.sz - Ang;
    end
    // rotation: drive angle toward zero
    if (d_i.rz >= 0) begin
      nxt.rx = d_i.rx - rdx;
      nxt.ry = d_i.ry + rdy;
      nxt.rz = d_i.rz - $signed({2'b00, Ang});
    end else begin
      nxt.rx = d_i.rx + rdx;
      nxt.ry = d_i.ry - rdy;
      nxt.rz = d_i.rz + $signed({2'b00, Ang});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      d_r <= nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

FILE: design/vivf_div_cell.sv
module vivf_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  vivf_pkg::pipe_t d_i,
  output logic            vld_o,
  output vivf_pkg::pipe_t d_o
);

  vivf_pkg::pipe_t nxt;
  logic [35:0]     fr_sh, vr_sh;
  logic            fr_q, vr_q;
  logic            vld_r;
  vivf_pkg::pipe_t d_r;

  // one quotient bit for the weight divider and the variance divider
  always_comb begin
    nxt   = d_i;
    fr_sh = {d_i.fr_rem[34:0], d_i.fr_low[31]};
    vr_sh = {d_i.vr_rem[34:0], d_i.vr_low[31]};
    fr_q  = (fr_sh >= {1'b0, d_i.fr_den});
    vr_q  = (vr_sh >= {3'b000, d_i.vr_den});
    nxt.fr_rem = fr_q ? (fr_sh - {1'b0, d_i.fr_den}) : fr_sh;
    nxt.vr_rem = vr_q ? (vr_sh - {3'b000, d_i.vr_den}) : vr_sh;
    nxt.fr_low = {d_i.fr_low[30:0], fr_q};
    nxt.vr_low = {d_i.vr_low[30:0], vr_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      d_r <= nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

FILE: design/velocity_inverse_variance_fusion.sv
// Velocity fusion of one associated pair of tracked objects (main, sub).
// Input channel: in_valid/in_ready with the main and sub headings, body
// velocities and variances. Result channel: out_valid/out_ready with the
// fused x velocity and variance plus the same_direction and applied flags.
// Configuration: cfg_wr_en/cfg_wr_data write merge_policy;
// write it only while no request is in flight.
// The pipe has 57 register stages; the entry stage loads on the accepting
// edge. It takes one request per cycle unless a stalled receiver holds it;
// the pipe is an entry stage, a row of 16 CORDIC cells (two vectoring, one
// rotation per cell), six arithmetic stages, a row of 32 divider cells that
// each retire one quotient bit, and two closing stages.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready drops in the same cycle; it resumes as soon as out_ready rises.
// Reset clears all stage valid bits and sets merge_policy to skip.
module velocity_inverse_variance_fusion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_main_heading,
  input  logic signed [31:0] in_main_vel_x,
  input  logic signed [31:0] in_main_vel_y,
  input  logic [31:0]        in_main_var_x,
  input  logic signed [15:0] in_sub_heading,
  input  logic signed [31:0] in_sub_vel_x,
  input  logic signed [31:0] in_sub_vel_y,
  input  logic [31:0]        in_sub_var_x,
  input  logic [31:0]        in_sub_var_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_fused_vel_x,
  output logic [31:0]        out_fused_var_x,
  output logic               out_same_direction,
  output logic               out_applied
);

  localparam int NC = vivf_pkg::CordicSteps;
  localparam int ND = vivf_pkg::DivSteps;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] o;
    if (v > 41'sd2147483647) begin
      o = 32'sh7FFFFFFF;
    end else if (v < -41'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  vivf_pkg::policy_t policy_r;
  logic              en;

  // the whole pipe advances unless a finished result waits unread
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= vivf_pkg::POL_SKIP;
    end else if (cfg_wr_en) begin
      policy_r <= vivf_pkg::policy_t'(cfg_wr_data);
    end
  end

  // ---------------- entry: fold inputs for the CORDIC rows ----------------
  vivf_pkg::pipe_t    s0_nxt, s0_r;
  logic               s0_vld_r;
  logic signed [15:0] ang_d;
  logic signed [17:0] ang_e;

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.pol   = policy_r;
    s0_nxt.mh    = in_main_heading;
    s0_nxt.sh    = in_sub_heading;
    s0_nxt.mvx   = in_main_vel_x;
    s0_nxt.mvy   = in_main_vel_y;
    s0_nxt.svx   = in_sub_vel_x;
    s0_nxt.svy   = in_sub_vel_y;
    s0_nxt.mvar  = in_main_var_x;
    s0_nxt.svarx = in_sub_var_x;
    s0_nxt.svary = in_sub_var_y;
    s0_nxt.mzero = (in_main_vel_x == 32'sd0) && (in_main_vel_y == 32'sd0);
    s0_nxt.szero = (in_sub_vel_x == 32'sd0) && (in_sub_vel_y == 32'sd0);
    // pre-rotate by a half turn into the right half plane
    if (in_main_vel_x < 0) begin
      s0_nxt.mx = -36'(in_main_vel_x);
      s0_nxt.my = -36'(in_main_vel_y);
      s0_nxt.mz = vivf_pkg::HalfTurn;
    end else begin
      s0_nxt.mx = 36'(in_main_vel_x);
      s0_nxt.my = 36'(in_main_vel_y);
      s0_nxt.mz = 16'd0;
    end
    if (in_sub_vel_x < 0) begin
      s0_nxt.sx = -36'(in_sub_vel_x);
      s0_nxt.sy = -36'(in_sub_vel_y);
      s0_nxt.sz = vivf_pkg::HalfTurn;
    end else begin
      s0_nxt.sx = 36'(in_sub_vel_x);
      s0_nxt.sy = 36'(in_sub_vel_y);
      s0_nxt.sz = 16'd0;
    end
    // fold the relative heading into a quarter turn either side
    ang_d = in_sub_heading - in_main_heading;
    ang_e = 18'(ang_d);
    if (ang_e > 18'sd16384) begin
      s0_nxt.rz  = ang_e - 18'sd32768;
      s0_nxt.neg = 1'b1;
    end else if (ang_e < -18'sd16384) begin
      s0_nxt.rz  = ang_e + 18'sd32768;
      s0_nxt.neg = 1'b1;
    end else begin
      s0_nxt.rz  = ang_e;
      s0_nxt.neg = 1'b0;
    end
    s0_nxt.rx = vivf_pkg::GainQ30;
    s0_nxt.ry = 34'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // ---------------- CORDIC row ----------------
  vivf_pkg::pipe_t cd [NC+1];
  logic            cv [NC+1];

  assign cd[0] = s0_r;
  assign cv[0] = s0_vld_r;

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    vivf_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (cv[i]),
      .d_i   (cd[i]),
      .vld_o (cv[i+1]),
      .d_o   (cd[i+1])
    );
  end

  // ---------------- arithmetic stages ----------------
  vivf_pkg::pipe_t    p1_nxt, p1_r, p2_nxt, p2_r, p3_nxt, p3_r;
  vivf_pkg::pipe_t    p4_nxt, p4_r, p5_nxt, p5_r, p6_nxt, p6_r;
  logic [5:0]         pv_r;
  logic [15:0]        mdir, sdir;
  logic signed [15:0] dir_d;
  logic signed [33:0] cosv, sinv;
  logic signed [66:0] rsum;
  logic [67:0]        c2t, s2t;
  logic [64:0]        vst;
  logic [34:0]        vsr;
  logic [51:0]        pq, pn, qn;
  logic [4:0]         nsh;
  logic [62:0]        frn;
  logic [64:0]        vrn;

  // direction check, rotate products
  always_comb begin
    p1_nxt = cd[NC];
    mdir   = cd[NC].mh + (cd[NC].mzero ? 16'd0 : cd[NC].mz);
    sdir   = cd[NC].sh + (cd[NC].szero ? 16'd0 : cd[NC].sz);
    dir_d  = mdir - sdir;
    p1_nxt.same = (dir_d > -vivf_pkg::EighthTurn) && (dir_d < vivf_pkg::EighthTurn);
    cosv   = cd[NC].neg ? -cd[NC].rx : cd[NC].rx;
    sinv   = cd[NC].neg ? -cd[NC].ry : cd[NC].ry;
    p1_nxt.pc = 66'(cd[NC].svx) * 66'(cosv);
    p1_nxt.ps = 66'(cd[NC].svy) * 66'(sinv);
    p1_nxt.cc = 68'(68'(cosv) * 68'(cosv));
    p1_nxt.ss = 68'(68'(sinv) * 68'(sinv));
  end

  // round to Q0 velocity and Q30 squares
  always_comb begin
    p2_nxt = p1_r;
    rsum   = 67'(p1_r.pc) + 67'(p1_r.ps) + 67'sd536870912;
    p2_nxt.r  = rsum[66:30];
    c2t    = p1_r.cc + 68'd536870912;
    s2t    = p1_r.ss + 68'd536870912;
    p2_nxt.c2 = c2t[61:30];
    p2_nxt.s2 = s2t[61:30];
  end

  // rotate the variance
  always_comb begin
    p3_nxt     = p2_r;
    p3_nxt.vxp = 64'(p2_r.svarx) * 64'(p2_r.c2);
    p3_nxt.vyp = 64'(p2_r.svary) * 64'(p2_r.s2);
  end

  // round and saturate the rotated variance
  always_comb begin
    p4_nxt    = p3_r;
    vst       = 65'(p3_r.vxp) + 65'(p3_r.vyp) + 65'd536870912;
    vsr       = vst[64:30];
    p4_nxt.vs = (vsr[34:32] != 3'b000) ? 32'hFFFFFFFF : vsr[31:0];
  end

  // weights, product and sum of the variances
  always_comb begin
    p5_nxt      = p4_r;
    p5_nxt.em   = (p4_r.mvar != 32'd0) ? 52'(p4_r.mvar) * vivf_pkg::VarScale
                                        : vivf_pkg::ZeroVarE;
    p5_nxt.es   = (p4_r.vs != 32'd0) ? 52'(p4_r.vs) * vivf_pkg::VarScale
                                      : vivf_pkg::ZeroVarE;
    p5_nxt.prod = 64'(p4_r.mvar) * 64'(p4_r.vs);
    p5_nxt.vsum = 33'(p4_r.mvar) + 33'(p4_r.vs);
  end

  // normalize weights below 2^34, load both dividers
  always_comb begin
    p6_nxt = p5_r;
    pq     = p5_r.em | p5_r.es;
    nsh    = 5'd0;
    for (int i = 0; i < 18; i++) begin
      if (pq[34+i]) begin
        nsh = 5'(i + 1);
      end
    end
    pn = p5_r.em >> nsh;
    qn = p5_r.es >> nsh;
    p6_nxt.fr_den = 35'(pn) + 35'(qn);
    frn    = {pn[34:0], 28'd0} + 63'(p6_nxt.fr_den >> 1);
    p6_nxt.fr_rem = 36'(frn[62:32]);
    p6_nxt.fr_low = frn[31:0];
    vrn    = 65'(p5_r.prod) + 65'(p5_r.vsum >> 1);
    p6_nxt.vr_rem = 36'(vrn[64:32]);
    p6_nxt.vr_low = vrn[31:0];
    p6_nxt.vr_den = p5_r.vsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[4:0], cv[NC]};
    end
    if (en) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
      p5_r <= p5_nxt;
      p6_r <= p6_nxt;
    end
  end

  // ---------------- divider row ----------------
  vivf_pkg::pipe_t dd [ND+1];
  logic            dv [ND+1];

  assign dd[0] = p6_r;
  assign dv[0] = pv_r[5];

  for (genvar j = 0; j < ND; j++) begin : g_div
    vivf_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv[j]),
      .d_i   (dd[j]),
      .vld_o (dv[j+1]),
      .d_o   (dd[j+1])
    );
  end

  // ---------------- blend and output ----------------
  vivf_pkg::pipe_t    p7_nxt, p7_r;
  logic               p7_vld_r;
  logic signed [37:0] vdiff;
  logic signed [67:0] dpr;
  logic signed [40:0] vel_f;
  logic signed [31:0] vel_nxt;
  logic [31:0]        var_nxt;
  logic               app_nxt;
  logic               out_valid_r;
  logic signed [31:0] vel_r;
  logic [31:0]        var_r;
  logic               same_r, app_r;

  always_comb begin
    p7_nxt    = dd[ND];
    vdiff     = 38'(dd[ND].r) - 38'(dd[ND].mvx);
    p7_nxt.dp = 68'(vdiff) * $signed({39'd0, dd[ND].fr_low[28:0]});
  end

  always_comb begin
    dpr     = p7_r.dp + 68'sd134217728;
    // keep the sign of the scaled step when widening it
    vel_f   = 41'(p7_r.mvx) + 41'($signed(dpr[67:28]));
    vel_nxt = p7_r.mvx;
    var_nxt = p7_r.mvar;
    app_nxt = 1'b0;
    if (p7_r.same) begin
      case (p7_r.pol)
        vivf_pkg::POL_OVERWRITE: begin
          vel_nxt = sat32(41'(p7_r.r));
          app_nxt = 1'b1;
        end
        vivf_pkg::POL_FUSION: begin
          vel_nxt = sat32(vel_f);
          var_nxt = ((p7_r.mvar == 32'd0) || (p7_r.vs == 32'd0)) ? 32'd0
                                                                 : p7_r.vr_low;
          app_nxt = 1'b1;
        end
        default: begin
          app_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p7_vld_r    <= dv[ND];
      out_valid_r <= p7_vld_r;
    end
    if (en) begin
      p7_r   <= p7_nxt;
      vel_r  <= vel_nxt;
      var_r  <= var_nxt;
      same_r <= p7_r.same;
      app_r  <= app_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fused_vel_x    = vel_r;
  assign out_fused_var_x    = var_r;
  assign out_same_direction = same_r;
  assign out_applied        = app_r;

endmodule
